// ===== sv/sacc_pkg.sv =====
// ----------------------------------------------------------------------------
// sacc_pkg: shared types and constants for the cache cost model
// Register indexes, word layouts and the per-set line record.
// ----------------------------------------------------------------------------
package sacc_pkg;

    localparam int MAX_SETS  = 256;
    localparam int MAX_WAYS  = 8;
    localparam int SET_W     = $clog2(MAX_SETS);
    localparam int WAY_W     = $clog2(MAX_WAYS);
    localparam int CNT_W     = $clog2(MAX_WAYS + 1);
    localparam int TAG_W     = 30;
    localparam int COST_W    = 14;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WB         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WA         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LRU        = 3'd5;

    typedef struct packed {
        logic        mode;
        logic [31:0] byte_addr;
    } t_in_word;

    typedef struct packed {
        logic              was_store;
        logic              hit;
        logic [COST_W-1:0] access_cycles;
        logic              dirty_evicted;
    } t_out_word;

    // One way of a set as kept in the set memory.
    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [WAY_W-1:0] rank;
        logic [TAG_W-1:0] tag;
    } t_line;

    typedef t_line [MAX_WAYS-1:0] t_set_row;

endpackage

// ===== sv/sacc_set_ram.sv =====
// ----------------------------------------------------------------------------
// sacc_set_ram: one row per set holding all ways, plus the fill count
// Synchronous read, registered into the cycle after the address; one write port.
// ----------------------------------------------------------------------------
module sacc_set_ram (
    input  logic                       i_clk,
    input  logic [sacc_pkg::SET_W-1:0] i_rd_addr,
    output sacc_pkg::t_set_row         o_rd_row,
    output logic [sacc_pkg::CNT_W-1:0] o_rd_fill,
    input  logic                       i_wr_en,
    input  logic [sacc_pkg::SET_W-1:0] i_wr_addr,
    input  sacc_pkg::t_set_row         i_wr_row,
    input  logic [sacc_pkg::CNT_W-1:0] i_wr_fill
);
    import sacc_pkg::*;

    t_set_row         r_row_mem  [MAX_SETS];
    logic [CNT_W-1:0] r_fill_mem [MAX_SETS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_row_mem[i_wr_addr]  <= i_wr_row;
            r_fill_mem[i_wr_addr] <= i_wr_fill;
        end
        o_rd_row  <= r_row_mem[i_rd_addr];
        o_rd_fill <= r_fill_mem[i_rd_addr];
    end

endmodule

// ===== sv/set_assoc_cache_cost_model_core.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_cost_model_core: set-associative cache cost model
// Looks up one load or store word, updates tags, order and status, and
// reports hit or miss with the cycle cost of the access.
// ----------------------------------------------------------------------------
//  Channel   Ports                            Handshake
//  command   i_start, i_in                    taken when i_start && !o_busy
//  result    o_done, o_out                    one-cycle strobe, no back pressure
//  config    i_cfg_we, i_cfg_idx, i_cfg_data  written at any edge with i_cfg_we
//
// Each word passes through S_READ, where the set row is read from the set
// memory, then S_UPDATE, where the ways are compared, the row is modified and
// written back, and the result word is registered. The read latency and the
// write back keep a new word out until the last is through; o_busy is high
// meanwhile. After reset the block first sweeps all MAX_SETS rows to clear
// valid bits and fill counts, with o_busy high throughout the sweep. The receiver
// cannot stall; o_done marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
module set_assoc_cache_cost_model_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  sacc_pkg::t_in_word             i_in,
    output logic                           o_busy,
    output logic                           o_done,
    output sacc_pkg::t_out_word            o_out,
    input  logic                           i_cfg_we,
    input  logic [sacc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sacc_pkg::CFG_W-1:0]     i_cfg_data
);
    import sacc_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPDATE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [3:0] r_set_bits;
    logic [3:0] r_ways;
    logic [2:0] r_block_bits;
    logic       r_wb, r_wa, r_lru;

    // The access in flight.
    logic       r_store;
    logic [31:0] r_addr;
    logic [SET_W-1:0] r_clr_idx;

    // Set memory ports.
    logic [SET_W-1:0] ram_rd_addr;
    t_set_row         ram_row;
    logic [CNT_W-1:0] ram_fill;
    logic             ram_we;
    logic [SET_W-1:0] ram_wr_addr;
    t_set_row         ram_wr_row;
    logic [CNT_W-1:0] ram_wr_fill;

    // Effective geometry.
    logic [3:0]       sib;
    logic [2:0]       bwb;
    logic [CNT_W-1:0] ways;
    logic [31:0]      set_mask;
    logic [SET_W-1:0] cur_set, in_set;
    logic [TAG_W-1:0] cur_tag;
    logic [COST_W-1:0] mem_cost;

    always_comb begin
        sib      = (r_set_bits > 4'(SET_W)) ? 4'(SET_W) : r_set_bits;
        bwb      = (r_block_bits > 3'd6) ? 3'd6 : r_block_bits;
        if (r_ways == 4'd0) begin
            ways = CNT_W'(1);
        end else if (r_ways > 4'(MAX_WAYS)) begin
            ways = CNT_W'(MAX_WAYS);
        end else begin
            ways = CNT_W'(r_ways);
        end
        set_mask = (32'd1 << sib) - 32'd1;
        cur_set  = SET_W'((r_addr >> (6'd2 + 6'(bwb))) & set_mask);
        in_set   = SET_W'((i_in.byte_addr >> (6'd2 + 6'(bwb))) & set_mask);
        cur_tag  = TAG_W'(r_addr >> (6'd2 + 6'(bwb) + 6'(sib)));
        // 100 * 2^bwb as 64*W + 32*W + 4*W.
        mem_cost = (COST_W'(64) << bwb) + (COST_W'(32) << bwb) + (COST_W'(4) << bwb);
    end

    // In S_IDLE the memory reads the set of the incoming word; afterwards it
    // reads the latched set, so the row seen in S_UPDATE belongs to the
    // accepted word even when i_in has already moved on.
    assign ram_rd_addr = (r_state == S_IDLE) ? in_set : cur_set;

    sacc_set_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_addr (ram_rd_addr),
        .o_rd_row  (ram_row),
        .o_rd_fill (ram_fill),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_row  (ram_wr_row),
        .i_wr_fill (ram_wr_fill)
    );

    // Lookup and update of the set row read in S_READ.
    logic             hit, full, dev;
    logic [WAY_W-1:0] hslot, hrank, vslot, fslot;
    logic             vdirty, do_ins, ins_dirty, bump_en;
    logic [WAY_W:0]   bump_lim;
    logic [COST_W-1:0] cost;
    t_set_row         new_row;
    logic [CNT_W-1:0] new_fill;

    always_comb begin
        hit   = 1'b0;
        hslot = '0;
        hrank = '0;
        vslot = '0;
        fslot = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (!ram_row[w].valid) begin
                fslot = WAY_W'(w);
            end
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (ram_row[w].valid && ram_row[w].tag == cur_tag &&
                (!hit || ram_row[w].rank < hrank)) begin
                hit   = 1'b1;
                hslot = WAY_W'(w);
                hrank = ram_row[w].rank;
            end
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (ram_row[w].valid && (CNT_W'(ram_row[w].rank) + CNT_W'(1)) == ram_fill) begin
                vslot = WAY_W'(w);
            end
        end
        full   = ram_fill >= ways;
        vdirty = full && (ram_fill != '0) && ram_row[vslot].dirty;

        dev       = 1'b0;
        do_ins    = 1'b0;
        ins_dirty = 1'b0;
        cost      = '0;
        if (hit) begin
            cost = (r_store && !r_wb) ? COST_W'(101) : COST_W'(1);
        end else if (!r_store) begin
            dev    = vdirty && r_wb && r_wa;
            cost   = COST_W'(1) + mem_cost + (dev ? mem_cost : '0);
            do_ins = 1'b1;
        end else if (!r_wb) begin
            do_ins = r_wa;
            cost   = r_wa ? (COST_W'(101) + mem_cost) : COST_W'(100);
        end else begin
            dev       = r_wa && vdirty;
            do_ins    = r_wa;
            ins_dirty = 1'b1;
            cost      = COST_W'(1) + mem_cost + (dev ? mem_cost : '0);
        end

        new_row  = ram_row;
        new_fill = ram_fill;
        bump_en  = 1'b0;
        bump_lim = '0;
        if (hit) begin
            if (r_store && r_wb) begin
                new_row[hslot].dirty = 1'b1;
            end
            bump_en  = r_lru;
            bump_lim = {1'b0, hrank};
        end else if (do_ins) begin
            bump_en = 1'b1;
            if (full && ram_fill != '0) begin
                new_row[vslot].valid = 1'b0;
                bump_lim = (WAY_W+1)'(ram_fill - CNT_W'(1));
            end else begin
                bump_lim = (WAY_W+1)'(ram_fill);
                new_fill = ram_fill + CNT_W'(1);
            end
        end
        if (bump_en) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (new_row[w].valid && {1'b0, new_row[w].rank} < bump_lim) begin
                    new_row[w].rank = new_row[w].rank + WAY_W'(1);
                end
            end
            if (hit) begin
                new_row[hslot].rank = '0;
            end else begin
                if (!(full && ram_fill != '0)) begin
                    vslot = fslot;
                end
                new_row[vslot].tag   = cur_tag;
                new_row[vslot].valid = 1'b1;
                new_row[vslot].dirty = ins_dirty;
                new_row[vslot].rank  = '0;
            end
        end
    end

    always_comb begin
        ram_we      = 1'b0;
        ram_wr_addr = cur_set;
        ram_wr_row  = new_row;
        ram_wr_fill = new_fill;
        if (r_state == S_CLEAR) begin
            ram_we      = 1'b1;
            ram_wr_addr = r_clr_idx;
            ram_wr_row  = '0;
            ram_wr_fill = '0;
        end else if (r_state == S_UPDATE) begin
            ram_we = 1'b1;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            o_done       <= 1'b0;
            r_set_bits   <= 4'd8;
            r_ways       <= 4'd8;
            r_block_bits <= 3'd2;
            r_wb         <= 1'b1;
            r_wa         <= 1'b1;
            r_lru        <= 1'b1;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SET_BITS:   r_set_bits   <= i_cfg_data;
                    REG_WAYS:       r_ways       <= i_cfg_data;
                    REG_BLOCK_BITS: r_block_bits <= i_cfg_data[2:0];
                    REG_WB:         r_wb         <= i_cfg_data[0];
                    REG_WA:         r_wa         <= i_cfg_data[0];
                    REG_LRU:        r_lru        <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + SET_W'(1);
                    if (r_clr_idx == SET_W'(MAX_SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_store <= i_in.mode;
                        r_addr  <= i_in.byte_addr;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    o_done              <= 1'b1;
                    o_out.was_store     <= r_store;
                    o_out.hit           <= hit;
                    o_out.access_cycles <= cost;
                    o_out.dirty_evicted <= dev;
                    r_state             <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |=> o_done) else $error("missing result strobe");
    a_no_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_UPDATE)) else $error("spurious result");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> (new_fill <= CNT_W'(MAX_WAYS)))
        else $error("fill count overflow");
    a_hit_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.hit) |-> !o_out.dirty_evicted)
        else $error("eviction on hit");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for set_assoc_cache_cost_model_core
// Drives load and store words through the command port under several cache
// settings. Each result word is checked against a built-in cache predictor.
// A short directed table comes first, then a random run with random gaps.
// ----------------------------------------------------------------------------
module testbench;
    import sacc_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_word  i_in;
    logic      o_busy;
    logic      o_done;
    t_out_word o_out;
    logic      i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    set_assoc_cache_cost_model_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_in(i_in),
        .o_busy(o_busy), .o_done(o_done), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Predictor state: a mirror of the cache tags, status bits and order.
    logic [TAG_W-1:0] mir_tag   [MAX_SETS][MAX_WAYS];
    logic             mir_valid [MAX_SETS][MAX_WAYS];
    logic             mir_dirty [MAX_SETS][MAX_WAYS];
    int unsigned      mir_rank  [MAX_SETS][MAX_WAYS];
    int unsigned      mir_fill  [MAX_SETS];
    int unsigned      cfg_sets, cfg_ways, cfg_blk;
    bit               cfg_wb, cfg_wa, cfg_lru;

    t_out_word pending_results[$];
    int        n_errors;
    int        n_words;
    int        n_checked;

    // Mark every set empty and return the registers to their reset values.
    task automatic reset_mirror();
        for (int s = 0; s < MAX_SETS; s++) begin
            mir_fill[s] = 0;
            for (int w = 0; w < MAX_WAYS; w++) begin
                mir_valid[s][w] = 1'b0;
                mir_dirty[s][w] = 1'b0;
                mir_rank[s][w]  = 0;
                mir_tag[s][w]   = '0;
            end
        end
        cfg_sets = 8; cfg_ways = 8; cfg_blk = 2;
        cfg_wb = 1'b1; cfg_wa = 1'b1; cfg_lru = 1'b1;
    endtask

    function automatic int unsigned find_victim(int unsigned s, int unsigned fill);
        for (int w = 0; w < MAX_WAYS; w++)
            if (mir_valid[s][w] && mir_rank[s][w] + 1 == fill) return w;
        return 0;
    endfunction

    // Ages every occupied way whose rank is below the limit.
    function automatic void age_ranks(int unsigned s, int unsigned limit);
        for (int w = 0; w < MAX_WAYS; w++)
            if (mir_valid[s][w] && mir_rank[s][w] < limit) mir_rank[s][w]++;
    endfunction

    function automatic void fill_front(int unsigned s, logic [TAG_W-1:0] tg, bit full,
                                       bit dty);
        int unsigned fill;
        int unsigned slot;
        fill = mir_fill[s];
        slot = 0;
        if (full && fill > 0) begin
            slot = find_victim(s, fill);
            mir_valid[s][slot] = 1'b0;
            age_ranks(s, fill - 1);
        end else begin
            for (int w = MAX_WAYS - 1; w >= 0; w--)
                if (!mir_valid[s][w]) slot = w;
            age_ranks(s, fill);
            mir_fill[s] = fill + 1;
        end
        mir_tag[s][slot]   = tg;
        mir_valid[s][slot] = 1'b1;
        mir_dirty[s][slot] = dty;
        mir_rank[s][slot]  = 0;
    endfunction

    // Computes the cost word of one access and updates the mirror.
    function automatic t_out_word predict_access(t_in_word wd);
        t_out_word r;
        int unsigned sib, bwb, ways, mem, s, fill, hslot, hrank, cost;
        logic [31:0] tg;
        bit hit, full, dev;
        sib  = cfg_sets;
        bwb  = (cfg_blk > 6) ? 6 : cfg_blk;
        ways = cfg_ways;
        while (sib > 0 && (1 << sib) > MAX_SETS) sib--;
        if (ways < 1) ways = 1;
        if (ways > MAX_WAYS) ways = MAX_WAYS;
        mem  = 100 * (1 << bwb);
        s    = (wd.byte_addr >> (2 + bwb)) & ((1 << sib) - 1);
        tg   = wd.byte_addr >> (2 + bwb + sib);
        fill = mir_fill[s];
        full = fill >= ways;
        hit = 1'b0; dev = 1'b0; hslot = 0; hrank = 0; cost = 0;
        for (int w = 0; w < MAX_WAYS; w++)
            if (mir_valid[s][w] && mir_tag[s][w] == tg[TAG_W-1:0] &&
                (!hit || mir_rank[s][w] < hrank)) begin
                hit = 1'b1; hslot = w; hrank = mir_rank[s][w];
            end
        if (hit) begin
            if (!wd.mode) cost = 1;
            else if (cfg_wb) begin
                mir_dirty[s][hslot] = 1'b1;
                cost = 1;
            end else cost = 101;
            if (cfg_lru) begin
                age_ranks(s, hrank);
                mir_rank[s][hslot] = 0;
            end
        end else if (!wd.mode) begin
            cost = 1 + mem;
            if (full && fill > 0 && cfg_wb && cfg_wa &&
                mir_dirty[s][find_victim(s, fill)]) begin
                cost += mem; dev = 1'b1;
            end
            fill_front(s, tg[TAG_W-1:0], full, 1'b0);
        end else if (!cfg_wb) begin
            if (cfg_wa) begin
                cost = 1 + mem + 100;
                fill_front(s, tg[TAG_W-1:0], full, 1'b0);
            end else cost = 100;
        end else begin
            cost = 1 + mem;
            if (cfg_wa) begin
                if (full && fill > 0 && mir_dirty[s][find_victim(s, fill)]) begin
                    cost += mem; dev = 1'b1;
                end
                fill_front(s, tg[TAG_W-1:0], full, 1'b1);
            end
        end
        r.was_store     = wd.mode;
        r.hit           = hit;
        r.access_cycles = cost[COST_W-1:0];
        r.dirty_evicted = dev;
        return r;
    endfunction

    // Registers are only written while the block is idle and nothing is owed.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_SET_BITS:   cfg_sets = val & 4'hF;
            REG_WAYS:       cfg_ways = val & 4'hF;
            REG_BLOCK_BITS: cfg_blk  = val & 3'h7;
            REG_WB:         cfg_wb   = val[0];
            REG_WA:         cfg_wa   = val[0];
            REG_LRU:        cfg_lru  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(int unsigned sb, int unsigned wy, int unsigned bb,
                              bit wb, bit wa, bit lru);
        write_reg(REG_SET_BITS, sb);
        write_reg(REG_WAYS, wy);
        write_reg(REG_BLOCK_BITS, bb);
        write_reg(REG_WB, 32'(wb));
        write_reg(REG_WA, 32'(wa));
        write_reg(REG_LRU, 32'(lru));
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Hands one word to the block after a gap of the given length and queues its result.
    // Called at a falling edge; o_busy only moves at rising edges, so the
    // value seen here holds for the next rising edge.
    task automatic send_access(bit st, logic [31:0] addr, int unsigned gap);
        t_in_word wd;
        repeat (gap) @(negedge i_clk);
        wd.mode = st;
        wd.byte_addr = addr;
        i_start = 1'b1;
        i_in    = wd;
        while (o_busy) @(negedge i_clk);
        pending_results.insert(pending_results.size(), predict_access(wd));
        n_words++;
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    // Result checking against the oldest expectation, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                n_errors++;
            end else begin
                t_out_word e;
                e = pending_results.pop_front();
                n_checked++;
                if (o_out.was_store !== e.was_store) begin
                    $error("was_store: expected %0d, got %0d", e.was_store, o_out.was_store);
                    n_errors++;
                end
                if (o_out.hit !== e.hit) begin
                    $error("hit: expected %0d, got %0d", e.hit, o_out.hit);
                    n_errors++;
                end
                if (o_out.access_cycles !== e.access_cycles) begin
                    $error("access_cycles: expected %0d, got %0d",
                           e.access_cycles, o_out.access_cycles);
                    n_errors++;
                end
                if (o_out.dirty_evicted !== e.dirty_evicted) begin
                    $error("dirty_evicted: expected %0d, got %0d",
                           e.dirty_evicted, o_out.dirty_evicted);
                    n_errors++;
                end
            end
        end
    end

    // Directed table. A typed-in cost of zero means the predictor is used alone.
    typedef struct {
        bit          st;
        logic [31:0] addr;
        int unsigned cost;
    } t_row;

    t_row dir_rows[] = '{
        '{1'b0, 32'h0000_0000, 401},  // cold load miss, W=4
        '{1'b0, 32'h0000_0000, 1},    // load hit
        '{1'b1, 32'h0000_0004, 1},    // store hit marks dirty
        '{1'b1, 32'hFFFF_FFFF, 401},  // store miss, write-back allocate
        '{1'b0, 32'hFFFF_FFFC, 1},
        '{1'b0, 32'h0001_0000, 0},    // same set, other tags
        '{1'b0, 32'h0002_0000, 0},
        '{1'b0, 32'h0003_0000, 0},
        '{1'b0, 32'h0004_0000, 0},
        '{1'b0, 32'h0005_0000, 0},
        '{1'b0, 32'h0006_0000, 0},
        '{1'b0, 32'h0007_0000, 0},    // set full now
        '{1'b0, 32'h0008_0000, 0},    // evicts, may be dirty
        '{1'b1, 32'h0009_0000, 0},
        '{1'b1, 32'hAAAA_AAAA, 0},
        '{1'b0, 32'h5555_5555, 0}
    };

    initial begin
        t_out_word e;
        int unsigned pool;
        i_rst_n = 1'b0; i_start = 1'b0; i_in = '0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        n_errors = 0; n_words = 0; n_checked = 0;
        reset_mirror();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings.
        foreach (dir_rows[k]) begin
            send_access(dir_rows[k].st, dir_rows[k].addr, k % 3);
            e = pending_results[$];
            if (dir_rows[k].cost != 0 && e.access_cycles != dir_rows[k].cost) begin
                $error("access_cycles: table expected %0d, predictor %0d",
                       dir_rows[k].cost, e.access_cycles);
                n_errors++;
            end
        end
        // The sender holds off until everything owed has come back.
        wait_drained();

        // Random phases, each under new settings, extremes first.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_config(0, 1, 0, 0, 0, 0);
                1: set_config(15, 15, 7, 1, 0, 1);
                2: set_config(8, 0, 6, 0, 1, 1);
                3: set_config(1, 2, 0, 1, 1, 0);
                default: set_config($urandom_range(0, 15), $urandom_range(0, 15),
                                    $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            // A small pool of blocks keeps hits and evictions frequent.
            pool = $urandom_range(0, 1) ? 32'h0000_0FFF : 32'h000F_FFFF;
            for (int k = 0; k < 85; k++) begin
                logic [31:0] a;
                a = ($urandom_range(0, 5) == 0) ? $urandom() : ($urandom() & pool);
                send_access(1'($urandom_range(0, 1)), a,
                            ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
            end
            wait_drained();
        end

        $display("testbench: %0d words sent, %0d results checked over 11 settings",
                 n_words, n_checked);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end
endmodule
